// File: design/lih_pkg.sv
// Shared constants, types and helper functions for the interval histogram.
package lih_pkg;

    // Field widths of the request, response and configuration beats.
    localparam int TS_W       = 63;
    localparam int BUCKET_W   = 4;
    localparam int REPORT_W   = 32;
    localparam int BASE_W     = 32;
    localparam int THR_W      = 64;

    // Default configuration of the block.
    localparam int NUM_BUCKETS_DEF = 10;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam logic [BASE_W-1:0] BASE_RESET = 32'd1000000000;

    // Request types.
    localparam logic REQ_EVENT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Values broadcast from the top level to every bucket cell.
    typedef struct packed {
        logic              fire;   // an event beat is accepted this cycle
        logic              armed;  // event request whose timestamp is not behind
        logic [TS_W-1:0]   delta;  // time since the last recorded event
        logic [BASE_W-1:0] base;   // smallest bucket interval
    } bcast_t;

    // Status returned by each bucket cell.
    typedef struct packed {
        logic                win;          // this cell takes the current event
        logic [REPORT_W-1:0] report_now;   // reported count before the event
        logic [REPORT_W-1:0] report_next;  // reported count after an increment
    } cell_stat_t;

    // Clamp a counter value to the width of the response count field.
    function automatic logic [REPORT_W-1:0] report_count(input logic [63:0] c);
        logic [REPORT_W-1:0] r;
        if (c[63:REPORT_W] != '0)
        begin
            r = '1;
        end
        else
        begin
            r = c[REPORT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/lih_req_if.sv
// Request channel: event timestamps and bucket reads.
interface lih_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [lih_pkg::TS_W-1:0]     timestamp_ns;
    logic [lih_pkg::BUCKET_W-1:0] read_bucket;

    modport source (output valid, output req_type, output timestamp_ns,
                    output read_bucket, input ready);
    modport sink   (input valid, input req_type, input timestamp_ns,
                    input read_bucket, output ready);
endinterface

// File: design/lih_rsp_if.sv
// Response channel: one result beat per request.
interface lih_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         recorded;
    logic [lih_pkg::BUCKET_W-1:0] bucket_index;
    logic [lih_pkg::REPORT_W-1:0] bucket_count;

    modport source (output valid, output recorded, output bucket_index,
                    output bucket_count, input ready);
    modport sink   (input valid, input recorded, input bucket_index,
                    input bucket_count, output ready);
endinterface

// File: design/lih_cfg_if.sv
// Configuration write channel for the base interval register.
interface lih_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lih_pkg::BASE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/lih_cell.sv
// One histogram bucket: threshold compare, priority link and saturating counter.
module lih_cell #(
    parameter int COUNT_WIDTH = lih_pkg::COUNT_WIDTH_DEF,
    parameter int BUCKET      = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lih_pkg::bcast_t     bc,
    input  logic                above_in,
    output logic                above_out,
    output lih_pkg::cell_stat_t stat
);

    logic [COUNT_WIDTH-1:0]     count_reg;
    logic [COUNT_WIDTH-1:0]     count_next;
    logic [COUNT_WIDTH-1:0]     count_inc;
    logic [lih_pkg::THR_W-1:0]  thr;
    logic                       hit;
    logic                       win;

    // Bucket threshold is the base interval doubled once per bucket position.
    assign thr = lih_pkg::THR_W'(bc.base) << BUCKET;
    assign hit = bc.armed && ({1'b0, bc.delta} >= thr);

    // A higher bucket that hits takes priority over this one.
    assign win       = hit && !above_in;
    assign above_out = above_in || hit;

    // Saturating increment.
    assign count_inc  = (count_reg == '1) ? count_reg
                      : count_reg + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    assign count_next = (bc.fire && win) ? count_inc : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign stat.win         = win;
    assign stat.report_now  = lih_pkg::report_count(64'(count_reg));
    assign stat.report_next = lih_pkg::report_count(64'(count_inc));

endmodule

// File: design/log2_interval_histogram.sv
// Top level: log2 activity interval histogram built from a row of bucket cells.
// A request beat yields its response beat in the cycle after it is accepted, from the output register.
// Throughput: one request per cycle while the response side is ready; the combinational path is the timestamp subtract,
// the per-cell threshold compares and the priority link through the row of cells.
// Reset clears all bucket counters and the stored event time, and loads the base
// interval with one second; the block accepts requests in the first cycle after reset.
module log2_interval_histogram #(
    parameter int NUM_BUCKETS = lih_pkg::NUM_BUCKETS_DEF,
    parameter int COUNT_WIDTH = lih_pkg::COUNT_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lih_req_if.sink   req,
    lih_rsp_if.source rsp,
    lih_cfg_if.sink   cfg
);

    localparam int SEL_W = 6;

    logic [lih_pkg::BASE_W-1:0]   base_reg;
    logic [lih_pkg::TS_W-1:0]     last_reg;
    logic [lih_pkg::TS_W-1:0]     last_next;
    logic                         rsp_valid_reg;
    logic                         recorded_reg;
    logic [lih_pkg::BUCKET_W-1:0] index_reg;
    logic [lih_pkg::REPORT_W-1:0] count_reg;

    logic                         accept;
    logic                         ts_ok;
    lih_pkg::bcast_t              bc;
    logic [NUM_BUCKETS:0]         above;
    lih_pkg::cell_stat_t          stat [NUM_BUCKETS];

    logic [lih_pkg::BUCKET_W-1:0] win_index;
    logic [lih_pkg::REPORT_W-1:0] win_count;
    logic [lih_pkg::REPORT_W-1:0] rd_count;
    logic                         recorded_next;
    logic [lih_pkg::BUCKET_W-1:0] index_next;
    logic [lih_pkg::REPORT_W-1:0] count_next;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    // A new beat enters while the output register is empty or being drained.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Interval since the last recorded event, broadcast to all cells.
    assign ts_ok    = req.timestamp_ns >= last_reg;
    assign bc.armed = (req.req_type == lih_pkg::REQ_EVENT) && ts_ok;
    assign bc.fire  = accept && (req.req_type == lih_pkg::REQ_EVENT);
    assign bc.delta = req.timestamp_ns - last_reg;
    assign bc.base  = base_reg;

    // Priority link runs from the highest bucket down to bucket zero.
    assign above[NUM_BUCKETS] = 1'b0;

    for (genvar g = 0; g < NUM_BUCKETS; g++)
    begin : g_cell
        lih_cell #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .BUCKET      (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bc        (bc),
            .above_in  (above[g+1]),
            .above_out (above[g]),
            .stat      (stat[g])
        );
    end

    // Gather the winning bucket and the bucket being read; at most one cell matches.
    always_comb
    begin
        win_index = '0;
        win_count = '0;
        rd_count  = '0;
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            if (stat[i].win)
            begin
                win_index = win_index | lih_pkg::BUCKET_W'(i);
                win_count = win_count | stat[i].report_next;
            end
            if ({{(SEL_W-lih_pkg::BUCKET_W){1'b0}}, req.read_bucket} == SEL_W'(i))
            begin
                rd_count = rd_count | stat[i].report_now;
            end
        end
    end

    // Response payload for the current request.
    always_comb
    begin
        recorded_next = 1'b0;
        index_next    = '0;
        count_next    = '0;
        last_next     = last_reg;
        if (req.req_type == lih_pkg::REQ_READ)
        begin
            index_next = req.read_bucket;
            count_next = rd_count;
        end
        else if (above[0])
        begin
            recorded_next = 1'b1;
            index_next    = win_index;
            count_next    = win_count;
            last_next     = req.timestamp_ns;
        end
    end

    // Control state: base interval, stored event time and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= lih_pkg::BASE_RESET;
            last_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                base_reg <= cfg.data;
            end
            if (accept)
            begin
                last_reg      <= last_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            recorded_reg <= recorded_next;
            index_reg    <= index_next;
            count_reg    <= count_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.recorded     = recorded_reg;
    assign rsp.bucket_index = index_reg;
    assign rsp.bucket_count = count_reg;

endmodule

// File: verif/log2_interval_histogram_tb.sv
`timescale 1ns / 1ps
// Testbench for log2_interval_histogram: request streams checked against a bucket predictor.
module log2_interval_histogram_tb;

    localparam int N_BUCKETS = lih_pkg::NUM_BUCKETS_DEF;
    localparam logic [lih_pkg::TS_W-1:0] TS_MAX = '1;
    localparam int STALL_MAX = 10;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS = 280;

    // One response beat as the block should produce it.
    typedef struct packed {
        logic                         recorded;
        logic [lih_pkg::BUCKET_W-1:0] index;
        logic [lih_pkg::REPORT_W-1:0] count;
    } bucket_result_t;

    logic clk = 1'b0;
    logic rst_n;

    lih_req_if req();
    lih_rsp_if rsp();
    lih_cfg_if cfg();

    log2_interval_histogram dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // Predicted histogram state.
    logic [lih_pkg::BASE_W-1:0]          base_ns;
    logic [lih_pkg::TS_W-1:0]            last_ts;
    logic [lih_pkg::COUNT_WIDTH_DEF-1:0] bucket_counts [N_BUCKETS];

    bucket_result_t pending_results [$];
    int error_count = 0;
    bit req_pacing = 1'b1;
    bit rsp_pacing = 1'b1;
    int rsp_hold = 0;
    int quiet_cycles = 0;

    always #6 clk = ~clk;

    // Apply one accepted request to the predicted state and return its response.
    function automatic bucket_result_t histogram_step(
        input logic                         kind,
        input logic [lih_pkg::TS_W-1:0]     ts,
        input logic [lih_pkg::BUCKET_W-1:0] rb);
        bucket_result_t r;
        logic [lih_pkg::TS_W-1:0] delta;
        logic [lih_pkg::THR_W-1:0] thr;
        r = '0;
        if (kind == lih_pkg::REQ_READ)
        begin
            r.index = rb;
            if (rb < N_BUCKETS)
            begin
                r.count = bucket_counts[rb];
            end
        end
        else if (ts >= last_ts)
        begin
            delta = ts - last_ts;
            // The highest bucket whose threshold the interval reaches takes the event.
            for (int i = N_BUCKETS - 1; i >= 0; i--)
            begin
                thr = lih_pkg::THR_W'(base_ns) << i;
                if (!r.recorded && {1'b0, delta} >= thr)
                begin
                    if (bucket_counts[i] != '1)
                    begin
                        bucket_counts[i]++;
                    end
                    last_ts    = ts;
                    r.recorded = 1'b1;
                    r.index    = lih_pkg::BUCKET_W'(i);
                    r.count    = bucket_counts[i];
                end
            end
        end
        return r;
    endfunction

    // Timestamp that lies the given span after the stored time, clamped to the field.
    function automatic logic [lih_pkg::TS_W-1:0] ts_after(input logic [63:0] span);
        logic [63:0] sum;
        sum = {1'b0, last_ts} + span;
        return (sum > {1'b0, TS_MAX}) ? TS_MAX : sum[lih_pkg::TS_W-1:0];
    endfunction

    function automatic logic [lih_pkg::TS_W-1:0] rand_ts();
        return lih_pkg::TS_W'({$urandom, $urandom});
    endfunction

    // Send one request beat and record what it should produce.
    task automatic send_item(input logic kind, input logic [lih_pkg::TS_W-1:0] ts,
                             input logic [lih_pkg::BUCKET_W-1:0] rb);
        int gap;
        gap = req_pacing ? $urandom_range(0, STALL_MAX) : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.req_type     <= kind;
        req.timestamp_ns <= ts;
        req.read_bucket  <= rb;
        do @(posedge clk); while (!req.ready);
        pending_results.push_back(histogram_step(kind, ts, rb));
    endtask

    task automatic send_event(input logic [lih_pkg::TS_W-1:0] ts);
        send_item(lih_pkg::REQ_EVENT, ts, lih_pkg::BUCKET_W'($urandom));
    endtask

    task automatic read_count(input logic [lih_pkg::BUCKET_W-1:0] rb);
        send_item(lih_pkg::REQ_READ, rand_ts(), rb);
    endtask

    // Stop sending and wait until every response has come back.
    task automatic drain();
        req.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_base(input logic [lih_pkg::BASE_W-1:0] value);
        drain();
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        base_ns = value;
    endtask

    // Reads of the cleared counters, in range and out of range, and an event at time zero.
    task automatic test_reset_state();
        read_count(4'd0);
        read_count(lih_pkg::BUCKET_W'(N_BUCKETS - 1));
        read_count(lih_pkg::BUCKET_W'(N_BUCKETS));
        read_count('1);
        send_event('0);
    endtask

    // Bucket edges at the default base, plus earlier and repeated timestamps.
    task automatic test_default_buckets();
        send_event(ts_after(64'(lih_pkg::BASE_RESET) - 1));
        send_event(ts_after(64'(lih_pkg::BASE_RESET)));
        send_event(ts_after(2 * 64'(lih_pkg::BASE_RESET) - 1));
        send_event(ts_after(64'(lih_pkg::BASE_RESET) << 5));
        send_event(ts_after(64'(lih_pkg::BASE_RESET) << (N_BUCKETS - 1)));
        send_event(ts_after(64'(lih_pkg::BASE_RESET) << (N_BUCKETS + 1)));
        send_event(last_ts - 1);
        send_event(last_ts);
        read_count(4'd0);
        read_count(4'd5);
        read_count(lih_pkg::BUCKET_W'(N_BUCKETS - 1));
    endtask

    // Smallest, zero and largest base interval.
    task automatic test_base_extremes();
        write_base(32'd1);
        send_event(ts_after(64'd1));
        send_event(ts_after(64'd1 << (N_BUCKETS - 1)));
        write_base('0);
        send_event(last_ts);
        write_base('1);
        send_event(ts_after(64'hFFFF_FFFF << (N_BUCKETS - 1)));
        send_event(ts_after(64'hFFFF_FFFE));
    endtask

    // Random traffic, mostly events placed around the bucket thresholds.
    task automatic test_random_phase(input logic [lih_pkg::BASE_W-1:0] base,
                                     input bit req_idle, input bit rsp_idle);
        int pick;
        int k;
        int off;
        logic [63:0] thr;
        logic [63:0] delta;
        write_base(base);
        req_pacing = req_idle;
        rsp_pacing = rsp_idle;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    read_count(lih_pkg::BUCKET_W'($urandom_range(0, 15)));
                end
                else
                begin
                    read_count(lih_pkg::BUCKET_W'($urandom_range(0, N_BUCKETS - 1)));
                end
            end
            else if (pick < 30)
            begin
                // Noise: a timestamp anywhere, or one just behind the stored time.
                off = $urandom_range(1, 1000);
                if ($urandom_range(0, 2) == 0)
                begin
                    send_event(rand_ts());
                end
                else
                begin
                    send_event((last_ts > lih_pkg::TS_W'(off))
                               ? last_ts - lih_pkg::TS_W'(off) : '0);
                end
            end
            else
            begin
                k = $urandom_range(0, N_BUCKETS);
                thr = 64'(base_ns) << k;
                case ($urandom_range(0, 4))
                    0: delta = thr;
                    1: delta = (thr == 0) ? 64'd0 : thr - 1;
                    2: delta = thr + $urandom_range(0, 3);
                    3: delta = thr + ({$urandom, $urandom} % (thr + 1));
                    default: delta = (base_ns == 0) ? 64'd0 : 64'($urandom % base_ns);
                endcase
                send_event(ts_after(delta));
            end
        end
    endtask

    // The largest timestamp, a repeat of it, and a timestamp far behind it.
    task automatic test_timestamp_extremes();
        write_base(lih_pkg::BASE_RESET);
        req_pacing = 1'b1;
        rsp_pacing = 1'b1;
        send_event(TS_MAX);
        send_event(TS_MAX);
        send_event('0);
        read_count(lih_pkg::BUCKET_W'(N_BUCKETS - 1));
    endtask

    // Response side: random stalls and comparison with the oldest prediction.
    always @(posedge clk)
    begin : rsp_check
        bucket_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected response beat: recorded=%0b index=%0d count=%0d",
                         $time, rsp.recorded, rsp.bucket_index, rsp.bucket_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if ({rsp.recorded, rsp.bucket_index, rsp.bucket_count} !== want)
                begin
                    error_count++;
                    $display({"%0t: mismatch: expected recorded=%0b index=%0d count=%0d,",
                              " got recorded=%0b index=%0d count=%0d"},
                             $time, want.recorded, want.index, want.count,
                             rsp.recorded, rsp.bucket_index, rsp.bucket_count);
                end
            end
            rsp_hold = rsp_pacing ? $urandom_range(0, STALL_MAX) : 0;
        end
        else if (rsp_hold > 0)
        begin
            rsp_hold--;
        end
        rsp.ready <= (rsp_hold == 0);
    end

    // Watchdog: ends the run when no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.req_type     = lih_pkg::REQ_EVENT;
        req.timestamp_ns = '0;
        req.read_bucket  = '0;
        cfg.valid        = 1'b0;
        cfg.data         = '0;
        base_ns          = lih_pkg::BASE_RESET;
        last_ts          = '0;
        for (int i = 0; i < N_BUCKETS; i++)
        begin
            bucket_counts[i] = '0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_default_buckets();
        test_base_extremes();
        test_random_phase(lih_pkg::BASE_RESET, 1'b0, 1'b0);
        test_random_phase(32'd1, 1'b1, 1'b1);
        test_random_phase('1, 1'b1, 1'b0);
        test_random_phase($urandom, 1'b0, 1'b1);
        test_random_phase(lih_pkg::BASE_W'($urandom_range(1, 64)), 1'b1, 1'b1);
        test_random_phase('0, 1'b1, 1'b1);
        test_timestamp_extremes();

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
